@@ hw/rtl/m4mul_pkg.sv @@
// Shared types and constants of the 4x4 fixed-point matrix multiplier.
package m4mul_pkg;

	// Default matrix dimension; the top level may override it (2 to 4)
	localparam int DIM_DEFAULT = 4;
	// Fraction bits of the Q16.16 element format
	localparam int FRAC_BITS = 16;
	localparam int VALUE_W = 32;
	localparam int INDEX_W = 4;
	localparam int PROD_W = 2 * VALUE_W;

	// Transaction operation codes
	typedef enum logic [1:0] {
		OP_LOAD_A   = 2'd0,
		OP_LOAD_B   = 2'd1,
		OP_MULTIPLY = 2'd2,
		OP_UNUSED   = 2'd3
	} m4mul_op_t;

	typedef struct packed {
		logic [1:0]                operation;
		logic [INDEX_W-1:0]        element_index;
		logic signed [VALUE_W-1:0] element_value;
	} m4mul_in_t;

	typedef struct packed {
		logic [INDEX_W-1:0]        product_index;
		logic signed [VALUE_W-1:0] product_value;
		logic                      last_element;
	} m4mul_out_t;

	// Sequencer commands to the datapath
	typedef struct packed {
		logic wr_a;   // write element of A
		logic wr_b;   // write element of B
		logic issue;  // read one A/B operand pair
		logic first;  // first term of a dot product
		logic last;   // final term of a dot product
	} m4mul_ctrl_t;

endpackage

@@ hw/rtl/m4mul_mac.sv @@
// Operand memories and the shared multiply-accumulate unit with output saturation.
module m4mul_mac #(
	parameter int DIM = m4mul_pkg::DIM_DEFAULT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  m4mul_pkg::m4mul_ctrl_t                 ctrl,
	input  logic [$clog2(DIM*DIM)-1:0]             wr_addr,
	input  logic [m4mul_pkg::VALUE_W-1:0]          wr_data,
	input  logic [$clog2(DIM*DIM)-1:0]             a_addr,
	input  logic [$clog2(DIM*DIM)-1:0]             b_addr,
	output logic                                   done,
	output logic signed [m4mul_pkg::VALUE_W-1:0]   result
);
	import m4mul_pkg::*;

	localparam int CELLS = DIM * DIM;
	localparam int ACC_W = PROD_W + $clog2(DIM);

	logic [VALUE_W-1:0] mem_a [CELLS];
	logic [VALUE_W-1:0] mem_b [CELLS];
	logic [CELLS-1:0]   vld_a_q;
	logic [CELLS-1:0]   vld_b_q;

	logic [VALUE_W-1:0] a_rd_s1;
	logic [VALUE_W-1:0] b_rd_s1;
	logic               a_ok_s1;
	logic               b_ok_s1;
	logic               issue_s1;
	logic               first_s1;
	logic               last_s1;

	logic signed [VALUE_W-1:0] op_a;
	logic signed [VALUE_W-1:0] op_b;
	logic signed [PROD_W-1:0]  prod_s2;
	logic                      issue_s2;
	logic                      first_s2;
	logic                      last_s2;

	logic signed [ACC_W-1:0]   acc_q;
	logic                      done_q;
	logic signed [ACC_W-1:0]   shifted;
	logic [ACC_W-VALUE_W:0]    upper;

	// Write element storage
	always_ff @(posedge clk) begin
		if (ctrl.wr_a) begin
			mem_a[wr_addr] <= wr_data;
		end
		if (ctrl.wr_b) begin
			mem_b[wr_addr] <= wr_data;
		end
	end

	// Mark written elements; unwritten ones read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_a_q <= '0;
			vld_b_q <= '0;
		end else begin
			if (ctrl.wr_a) begin
				vld_a_q[wr_addr] <= 1'b1;
			end
			if (ctrl.wr_b) begin
				vld_b_q[wr_addr] <= 1'b1;
			end
		end
	end

	// Read one operand pair
	always_ff @(posedge clk) begin
		if (ctrl.issue) begin
			a_rd_s1 <= mem_a[a_addr];
			b_rd_s1 <= mem_b[b_addr];
			a_ok_s1 <= vld_a_q[a_addr];
			b_ok_s1 <= vld_b_q[b_addr];
		end
	end

	assign op_a = a_ok_s1 ? signed'(a_rd_s1) : '0;
	assign op_b = b_ok_s1 ? signed'(b_rd_s1) : '0;

	// Multiply
	always_ff @(posedge clk) begin
		if (issue_s1) begin
			prod_s2 <= op_a * op_b;
		end
	end

	// Accumulate at full width
	always_ff @(posedge clk) begin
		if (issue_s2) begin
			acc_q <= first_s2 ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
		end
	end

	// Advance the term tags alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			issue_s2 <= 1'b0;
			first_s2 <= 1'b0;
			last_s2  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			issue_s1 <= ctrl.issue;
			first_s1 <= ctrl.first;
			last_s1  <= ctrl.last;
			issue_s2 <= issue_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			done_q   <= issue_s2 & last_s2;
		end
	end

	// Drop fraction bits (floor) and clamp to the 32-bit range
	assign shifted = acc_q >>> FRAC_BITS;
	assign upper   = shifted[ACC_W-1:VALUE_W-1];

	always_comb begin
		if ((upper == '0) || (upper == '1)) begin
			result = shifted[VALUE_W-1:0];
		end else if (shifted[ACC_W-1]) begin
			result = {1'b1, {(VALUE_W-1){1'b0}}};
		end else begin
			result = {1'b0, {(VALUE_W-1){1'b1}}};
		end
	end

	assign done = done_q;

endmodule

@@ hw/rtl/m4mul_seq.sv @@
// Sequencer: input decode, row/column/term counters and the result register.
module m4mul_seq #(
	parameter int DIM = m4mul_pkg::DIM_DEFAULT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  m4mul_pkg::m4mul_in_t                   in_data,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output m4mul_pkg::m4mul_out_t                  out_data,
	output m4mul_pkg::m4mul_ctrl_t                 ctrl,
	output logic [$clog2(DIM*DIM)-1:0]             wr_addr,
	output logic [m4mul_pkg::VALUE_W-1:0]          wr_data,
	output logic [$clog2(DIM*DIM)-1:0]             a_addr,
	output logic [$clog2(DIM*DIM)-1:0]             b_addr,
	input  logic                                   done,
	input  logic signed [m4mul_pkg::VALUE_W-1:0]   result
);
	import m4mul_pkg::*;

	localparam int CELLS = DIM * DIM;
	localparam int KW    = $clog2(DIM);
	localparam int AW    = $clog2(CELLS);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RUN   = 4'b0010,
		S_DRAIN = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	state_t        state_q;
	logic [KW-1:0] row_q;
	logic [KW-1:0] col_q;
	logic [KW-1:0] k_q;
	logic          accept;
	logic          in_range;
	logic          k_end;
	logic          col_end;
	logic          row_end;
	logic          out_free;
	logic [AW-1:0] pos;
	logic          out_valid_q;
	m4mul_out_t    out_q;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid & in_ready;
	assign in_range = 32'(in_data.element_index) < CELLS;
	assign k_end    = (k_q == KW'(DIM - 1));
	assign col_end  = (col_q == KW'(DIM - 1));
	assign row_end  = (row_q == KW'(DIM - 1));
	assign out_free = !out_valid_q || out_ready;
	assign pos      = AW'(32'(row_q) * DIM + 32'(col_q));

	// Element writes straight from the load transaction
	assign wr_addr    = AW'(in_data.element_index);
	assign wr_data    = in_data.element_value;
	assign ctrl.wr_a  = accept && (in_data.operation == OP_LOAD_A) && in_range;
	assign ctrl.wr_b  = accept && (in_data.operation == OP_LOAD_B) && in_range;

	// One operand pair per cycle while running
	assign ctrl.issue = (state_q == S_RUN);
	assign ctrl.first = (state_q == S_RUN) && (k_q == '0);
	assign ctrl.last  = (state_q == S_RUN) && k_end;
	assign a_addr     = AW'(32'(row_q) * DIM + 32'(k_q));
	assign b_addr     = AW'(32'(k_q) * DIM + 32'(col_q));

	// Step through rows, columns and terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && (in_data.operation == OP_MULTIPLY)) begin
						row_q   <= '0;
						col_q   <= '0;
						k_q     <= '0;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (k_end) begin
						k_q     <= '0;
						state_q <= S_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						if (col_end) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
						state_q <= (col_end && row_end) ? S_IDLE : S_RUN;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold each result until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_EMIT) && out_free) begin
			out_q.product_index <= INDEX_W'(pos);
			out_q.product_value <= result;
			out_q.last_element  <= col_end && row_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ hw/rtl/matrix4_multiply_unit.sv @@
// Top level of the fixed-point matrix multiplier.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_data  (m4mul_in_t: op, index, value)
//  out     | output    | out_valid/ out_ready | out_data (m4mul_out_t: index, value, last)
//
//  A multiply transaction holds in_ready low while it runs: each product element
//  takes DIM operand reads through the single shared multiplier, then passes
//  through multiply, accumulate and saturate on its way to the result register.
//  A stalled output stretches the element that waits to enter the result register.
//  Reset clears both matrices to zero and returns the sequencer to idle.
module matrix4_multiply_unit #(
	parameter int DIM = m4mul_pkg::DIM_DEFAULT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  m4mul_pkg::m4mul_in_t    in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output m4mul_pkg::m4mul_out_t   out_data
);
	import m4mul_pkg::*;

	localparam int AW = $clog2(DIM * DIM);

	m4mul_ctrl_t               ctrl;
	logic [AW-1:0]             wr_addr;
	logic [VALUE_W-1:0]        wr_data;
	logic [AW-1:0]             a_addr;
	logic [AW-1:0]             b_addr;
	logic                      done;
	logic signed [VALUE_W-1:0] result;

	m4mul_seq #(
		.DIM(DIM)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.ctrl     (ctrl),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.a_addr   (a_addr),
		.b_addr   (b_addr),
		.done     (done),
		.result   (result)
	);

	m4mul_mac #(
		.DIM(DIM)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.a_addr (a_addr),
		.b_addr (b_addr),
		.done   (done),
		.result (result)
	);

endmodule
